>>> rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/fwws_pkg.sv
// Shared types and constants of the weighted window filter.
`default_nettype none
package fwws_pkg;

    localparam int PIX_W = 24;
    localparam int WGT_W = 16;
    localparam int ACC_W = 48;
    localparam int PROD_W = PIX_W + WGT_W;

    // Request kinds on the input stream; the last code is unused and ignored.
    localparam logic [1:0] OP_PIXEL    = 2'd0;
    localparam logic [1:0] OP_DRAIN    = 2'd1;
    localparam logic [1:0] OP_WEIGHT   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_HALF_ROWS = 3'd2;
    localparam logic [2:0] CFG_HALF_COLS = 3'd3;
    localparam logic [2:0] CFG_REMOVE_NA = 3'd4;
    localparam logic [2:0] CFG_NA_FILL   = 3'd5;
    localparam logic [2:0] CFG_MEAN      = 3'd6;

    // One stored pixel with its missing flag.
    typedef struct packed {
        logic                    na;
        logic signed [PIX_W-1:0] value;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTR_RD,
        ST_CTR_CHK,
        ST_MAC,
        ST_MAC_END,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

>>> rtl/fwws_line_mem.sv
// Line store: simple dual-port memory with a registered read.
`default_nettype none
module fwws_line_mem
    import fwws_pkg::*;
#(
    parameter int DEPTH = 5120,
    parameter int AW    = 13
) (
    input  wire          i_clk,
    input  wire          i_wr_en,
    input  wire [AW-1:0] i_wr_addr,
    input  t_cell        i_wr_data,
    input  wire          i_rd_en,
    input  wire [AW-1:0] i_rd_addr,
    output t_cell        o_rd_data
);

    t_cell r_mem [DEPTH];
    t_cell r_rd;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule
`default_nettype wire

>>> rtl/fwws_div.sv
// Signed by unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module fwws_div
    import fwws_pkg::*;
#(
    parameter int DW = 5
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire signed [ACC_W-1:0]  i_dividend,
    input  wire        [DW-1:0]     i_divisor,
    output logic                    o_done,
    output logic signed [ACC_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0] r_mag;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;
    logic             ge;

    // Shift in the next dividend bit and try the subtraction.
    always_comb begin
        rem_sh  = {r_rem, r_mag[ACC_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath; the quotient builds up in the magnitude register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[ACC_W-1];
            r_mag <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_mag <= {r_mag[ACC_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule
`default_nettype wire

>>> rtl/focal_weighted_window_sum.sv
// Top level of the weighted window filter with missing-value handling.
//
//  port group      dir  payload (low bit first)
//  s_axis          in   tdata: pixel_value[23:0] weight_index[28:24] weight_value[44:29]
//                       tuser: op[1:0] pixel_is_na[2]
//  m_axis          out  tdata: result_value[47:0]; tuser: result_is_na; tlast: result_last
//  cfg             in   wr_en, index[2:0], data[15:0]
//
// A request with no result is taken while idle. An edge or pass-through result
// passes the counter read, counter check and output states; an interior result
// also walks the window from the line store, one tap per cycle, through the
// multiply-accumulate; a mean adds the bit-serial divider. Reset is synchronous
// and active low; the line store is not cleared. A held result does not stop the
// next request from entering; only the following result waits for the output.
`default_nettype none
`include "assert_macros.svh"
module focal_weighted_window_sum
    import fwws_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HALF_ROWS = 2,
    parameter int MAX_HALF_COLS = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,   // pixel_value, weight_index, weight_value
    input  wire  [2:0]  i_s_axis_tuser,   // op, pixel_is_na
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // result_value
    output logic        o_m_axis_tuser,   // result_is_na
    output logic        o_m_axis_tlast,
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int RING  = 2 * MAX_HALF_ROWS + 1;
    localparam int RW    = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int WW1   = WW + 1;
    localparam int TAPS  = (2 * MAX_HALF_ROWS + 1) * (2 * MAX_HALF_COLS + 1);
    localparam int TW    = $clog2(TAPS);
    localparam int QW    = $clog2(TAPS + 1);
    localparam int HRW   = $clog2(MAX_HALF_ROWS + 1);
    localparam int HCW   = $clog2(MAX_HALF_COLS + 1);
    localparam int DCW   = $clog2(2 * MAX_HALF_COLS + 1);
    localparam int PW    = $clog2(MAX_HALF_ROWS * MAX_WIDTH + MAX_HALF_COLS + 2);
    localparam int AW    = RW + CW;
    localparam int DEPTH = RING * (2 ** CW);

    // Configuration registers.
    logic [10:0] r_cfg_width;
    logic [15:0] r_cfg_height;
    logic [1:0]  r_cfg_hr;
    logic [1:0]  r_cfg_hc;
    logic        r_cfg_rm;
    logic        r_cfg_fill;
    logic        r_cfg_mean;

    t_state r_state, n_state;

    // Position counters.
    logic [15:0]   r_in_row, r_out_row;
    logic [WW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_ring, r_out_ring;
    logic [PW-1:0] r_pend;

    // Tap walk.
    logic [RW-1:0]  r_tr_ring, r_dr;
    logic [DCW-1:0] r_dc;
    logic [WW-1:0]  r_tk;
    logic [QW-1:0]  r_q, r_p;
    logic           r_iss_done, r_rd_v, r_prod_v, r_prod_na, r_any;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // Weights.
    logic signed [WGT_W-1:0] r_wmem [TAPS];
    logic [TAPS-1:0]         r_wvalid;
    logic signed [WGT_W-1:0] r_wt_rd;
    logic                    r_wt_ok;

    // Result and output register.
    logic signed [ACC_W-1:0] r_res_val, r_out_val;
    logic r_res_na, r_out_na, r_out_last, r_out_v;

    // Derived geometry.
    logic [WW-1:0]  eff_w;
    logic [15:0]    eff_h;
    logic [HRW-1:0] eff_hr;
    logic [HCW-1:0] eff_hc;
    logic [PW-1:0]  lag;
    logic           interior, last, geom_wr;
    logic [RW:0]    ring_sum;
    logic [RW-1:0]  ring_top;

    logic [1:0] s_op;
    logic       accept, pix_ok, pix_acc, start_emit, pass_ctr, na_sum;
    logic       mac_issue, mem_rd_en, div_start, out_load, div_done;
    logic [AW-1:0] mem_rd_addr, mem_wr_addr;
    t_cell      wr_cell, rd_cell;
    logic signed [ACC_W-1:0] div_q;
    logic [QW-1:0] div_dvs;

    // Effective geometry after clamping.
    always_comb begin
        if (r_cfg_width == 11'd0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_width);
        end
        eff_h  = (r_cfg_height == 16'd0) ? 16'd1 : r_cfg_height;
        eff_hr = (32'(r_cfg_hr) > MAX_HALF_ROWS) ? HRW'(MAX_HALF_ROWS) : HRW'(r_cfg_hr);
        eff_hc = (32'(r_cfg_hc) > MAX_HALF_COLS) ? HCW'(MAX_HALF_COLS) : HCW'(r_cfg_hc);
        lag    = PW'(32'(eff_hr) * 32'(eff_w) + 32'(eff_hc));
    end

    // Window position of the pending result.
    always_comb begin
        interior = (17'(r_out_row) >= 17'(eff_hr))
                && (17'(r_out_row) + 17'(eff_hr) < 17'(eff_h))
                && (WW1'(r_out_col) >= WW1'(eff_hc))
                && (WW1'(r_out_col) + WW1'(eff_hc) < WW1'(eff_w));
        last     = (17'(r_out_row) + 17'd1 == 17'(eff_h))
                && (WW1'(r_out_col) + WW1'(1) == WW1'(eff_w));
        ring_sum = {1'b0, r_out_ring} + (RW+1)'(RING) - (RW+1)'(eff_hr);
        ring_top = (ring_sum >= (RW+1)'(RING)) ? RW'(ring_sum - (RW+1)'(RING))
                                               : RW'(ring_sum);
    end

    // Input decode.
    always_comb begin
        s_op       = i_s_axis_tuser[1:0];
        accept     = i_s_axis_tvalid && o_s_axis_tready;
        pix_ok     = r_in_row < eff_h;
        pix_acc    = accept && (s_op == OP_PIXEL) && pix_ok;
        start_emit = (pix_acc && ((r_pend + 1'b1) > lag))
                  || (accept && (s_op == OP_DRAIN) && !pix_ok && (r_out_row < eff_h));
        pass_ctr   = r_cfg_rm && r_cfg_fill && (!interior || !rd_cell.na);
        na_sum     = r_cfg_rm ? (r_p == '0) : r_any;
        geom_wr    = i_cfg_wr_en && ((i_cfg_index == CFG_WIDTH)
                  || (i_cfg_index == CFG_HEIGHT) || (i_cfg_index == CFG_HALF_ROWS)
                  || (i_cfg_index == CFG_HALF_COLS));
        wr_cell.na    = i_s_axis_tuser[2];
        wr_cell.value = i_s_axis_tdata[PIX_W-1:0];
        mem_wr_addr   = {r_in_ring, r_in_col[CW-1:0]};
        div_dvs       = r_cfg_rm ? r_p : r_q;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (start_emit) n_state = ST_CTR_RD;
            ST_CTR_RD:  n_state = ST_CTR_CHK;
            ST_CTR_CHK: n_state = (pass_ctr || !interior) ? ST_OUT : ST_MAC;
            ST_MAC: begin
                if (r_iss_done && !r_rd_v && !r_prod_v) n_state = ST_MAC_END;
            end
            ST_MAC_END: n_state = (!na_sum && r_cfg_mean) ? ST_DIV : ST_OUT;
            ST_DIV:     if (div_done) n_state = ST_OUT;
            ST_OUT:     if (out_load) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        mac_issue       = (r_state == ST_MAC) && !r_iss_done;
        mem_rd_en       = (r_state == ST_CTR_RD) || mac_issue;
        mem_rd_addr     = (r_state == ST_CTR_RD) ? {r_out_ring, r_out_col[CW-1:0]}
                                                 : {r_tr_ring, r_tk[CW-1:0]};
        div_start       = (r_state == ST_MAC_END) && !na_sum && r_cfg_mean;
        out_load        = (r_state == ST_OUT) && (!r_out_v || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 11'd1024;
            r_cfg_height <= 16'd1024;
            r_cfg_hr     <= 2'd1;
            r_cfg_hc     <= 2'd1;
            r_cfg_rm     <= 1'b0;
            r_cfg_fill   <= 1'b0;
            r_cfg_mean   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WIDTH:     r_cfg_width  <= i_cfg_data[10:0];
                CFG_HEIGHT:    r_cfg_height <= i_cfg_data;
                CFG_HALF_ROWS: r_cfg_hr     <= i_cfg_data[1:0];
                CFG_HALF_COLS: r_cfg_hc     <= i_cfg_data[1:0];
                CFG_REMOVE_NA: r_cfg_rm     <= i_cfg_data[0];
                CFG_NA_FILL:   r_cfg_fill   <= i_cfg_data[0];
                CFG_MEAN:      r_cfg_mean   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input and output positions, and the count of pixels not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_wr || (out_load && last)) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_ring  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_ring <= '0;
            r_pend     <= '0;
        end else if (pix_acc) begin
            r_pend <= r_pend + 1'b1;
            if (WW1'(r_in_col) + WW1'(1) >= WW1'(eff_w)) begin
                r_in_col  <= '0;
                r_in_row  <= r_in_row + 16'd1;
                r_in_ring <= (r_in_ring == RW'(RING - 1)) ? '0 : r_in_ring + 1'b1;
            end else begin
                r_in_col <= r_in_col + 1'b1;
            end
        end else if (out_load) begin
            r_pend <= r_pend - 1'b1;
            if (WW1'(r_out_col) + WW1'(1) >= WW1'(eff_w)) begin
                r_out_col  <= '0;
                r_out_row  <= r_out_row + 16'd1;
                r_out_ring <= (r_out_ring == RW'(RING - 1)) ? '0 : r_out_ring + 1'b1;
            end else begin
                r_out_col <= r_out_col + 1'b1;
            end
        end
    end

    // Weight table with per-entry valid bits; an unwritten weight reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (accept && (s_op == OP_WEIGHT)
                     && (32'(i_s_axis_tdata[28:24]) < TAPS)) begin
            r_wvalid[TW'(i_s_axis_tdata[28:24])] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (s_op == OP_WEIGHT) && (32'(i_s_axis_tdata[28:24]) < TAPS)) begin
            r_wmem[TW'(i_s_axis_tdata[28:24])] <= i_s_axis_tdata[44:29];
        end
        if (mac_issue) begin
            r_wt_rd <= r_wmem[r_q[TW-1:0]];
            r_wt_ok <= r_wvalid[r_q[TW-1:0]];
        end
    end

    // Tap walk pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= mac_issue;
            r_prod_v <= r_rd_v;
        end
    end

    // Window walk: issue, multiply, accumulate.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CTR_CHK) begin
            r_tr_ring  <= ring_top;
            r_tk       <= r_out_col - WW'(eff_hc);
            r_dr       <= '0;
            r_dc       <= '0;
            r_q        <= '0;
            r_p        <= '0;
            r_any      <= 1'b0;
            r_acc      <= '0;
            r_iss_done <= 1'b0;
        end else begin
            if (mac_issue) begin
                r_q <= r_q + 1'b1;
                if (r_dc == DCW'({eff_hc, 1'b0})) begin
                    r_dc <= '0;
                    r_tk <= r_out_col - WW'(eff_hc);
                    if (r_dr == RW'({eff_hr, 1'b0})) begin
                        r_iss_done <= 1'b1;
                    end else begin
                        r_dr      <= r_dr + 1'b1;
                        r_tr_ring <= (r_tr_ring == RW'(RING - 1)) ? '0 : r_tr_ring + 1'b1;
                    end
                end else begin
                    r_dc <= r_dc + 1'b1;
                    r_tk <= r_tk + 1'b1;
                end
            end
            if (r_prod_v) begin
                if (r_prod_na) begin
                    r_any <= 1'b1;
                end else begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                    r_p   <= r_p + 1'b1;
                end
            end
        end
        if (r_rd_v) begin
            r_prod    <= rd_cell.value * (r_wt_ok ? r_wt_rd : WGT_W'(0));
            r_prod_na <= rd_cell.na;
        end
    end

    // Result selection. Sums stay well inside 48 bits, so no clamp is needed.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_CTR_CHK: begin
                if (pass_ctr) begin
                    r_res_na  <= rd_cell.na;
                    r_res_val <= rd_cell.na ? '0
                               : {{(ACC_W-PIX_W-8){rd_cell.value[PIX_W-1]}},
                                  rd_cell.value, 8'd0};
                end else begin
                    r_res_na  <= 1'b1;
                    r_res_val <= '0;
                end
            end
            ST_MAC_END: begin
                r_res_na  <= na_sum;
                r_res_val <= na_sum ? '0 : r_acc;
            end
            ST_DIV: begin
                if (div_done) begin
                    r_res_val <= div_q;
                end
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_val  <= r_res_val;
            r_out_na   <= r_res_na;
            r_out_last <= last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = r_out_na;
    assign o_m_axis_tlast  = r_out_last;

    fwws_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (pix_acc),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (wr_cell),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rd_cell)
    );

    fwws_div #(
        .DW (QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Checks.
    `ASSERT_IMPLIES(a_pend_bound, i_clk, i_rst_n, r_state == ST_IDLE, r_pend <= lag)
    `ASSERT_IMPLIES(a_out_row_valid, i_clk, i_rst_n, r_state != ST_IDLE, r_out_row < eff_h)
    `ASSERT_NEXT(a_load_to_idle, i_clk, i_rst_n, out_load, r_out_v && (r_state == ST_IDLE))

endmodule
`default_nettype wire
